[hw/rtl/torus_vertex_generator_macros.svh]
// Assertion macros for the torus vertex generator.
`ifndef TORUS_VERTEX_GENERATOR_MACROS_SVH
`define TORUS_VERTEX_GENERATOR_MACROS_SVH
// Implication checked every clock edge while out of reset.
`define TVG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock edge while out of reset.
`define TVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/tvg_pkg.sv]
// Package: constants, types and trig helpers for the torus vertex generator.
package tvg_pkg;
  localparam int SIDE_SLICES = 8;
  localparam int RING_SLICES = 8;

  // cycles for the config-angle sine/cosine registers to settle
  localparam logic [1:0] TRIG_LAT = 2'd3;

  localparam logic [2:0] REG_TUBE = 3'd0;
  localparam logic [2:0] REG_RING = 3'd1;
  localparam logic [2:0] REG_AX   = 3'd2;
  localparam logic [2:0] REG_AY   = 3'd3;
  localparam logic [2:0] REG_AZ   = 3'd4;
  localparam logic [2:0] REG_OX   = 3'd5;
  localparam logic [2:0] REG_OY   = 3'd6;
  localparam logic [2:0] REG_OZ   = 3'd7;

  typedef struct packed {
    logic signed [31:0] tube;
    logic signed [31:0] ring;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [15:0]        az;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
  } cfg_t;

  // one vertex job entering the transform pipe
  typedef struct packed {
    logic signed [15:0] ct;
    logic signed [15:0] st;
    logic signed [15:0] cp;
    logic signed [15:0] sp;
    logic               tilt;
    logic               last;
  } job_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
    logic               last;
  } vert_t;

  function automatic logic [15:0] step_angle(input logic [6:0] step, input int slices);
    logic [31:0] v;
    v = (32'(step) * 32'd65536 + 32'(slices / 2)) / 32'(slices);
    return v[15:0];
  endfunction

  function automatic logic [14:0] quarter_sine(input logic [14:0] f);
    logic [31:0] x, x2, t;
    x  = 32'(f);
    x2 = (x * x) >> 14;
    t  = (32'd1160 * x2) >> 14;
    t  = 32'd10512 - t;
    t  = (t * x2) >> 14;
    t  = 32'd25736 - t;
    t  = (t * x) >> 14;
    return t[14:0];
  endfunction

  function automatic logic signed [15:0] sin16(input logic [15:0] a);
    logic [14:0] s;
    s = a[14] ? quarter_sine(15'd16384 - {1'b0, a[13:0]}) : quarter_sine({1'b0, a[13:0]});
    return a[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  function automatic logic signed [15:0] cos16(input logic [15:0] a);
    return sin16(a + 16'd16384);
  endfunction

  // Constant table: trig per step index, ring 0..15 and side 0..31 (angle wraps).
  function automatic logic signed [15:0] ring_cos(input logic [3:0] k);
    return cos16(step_angle({3'd0, k}, RING_SLICES));
  endfunction
  function automatic logic signed [15:0] ring_sin(input logic [3:0] k);
    return sin16(step_angle({3'd0, k}, RING_SLICES));
  endfunction
  function automatic logic signed [15:0] side_cos(input logic [4:0] j);
    return cos16(step_angle({2'd0, j}, SIDE_SLICES));
  endfunction
  function automatic logic signed [15:0] side_sin(input logic [4:0] j);
    return sin16(step_angle({2'd0, j}, SIDE_SLICES));
  endfunction

  function automatic logic signed [63:0] rnd14(input logic signed [63:0] p);
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

[hw/rtl/tvg_turn.sv]
// One plane rotation stage over position and normal vectors, registered.
module tvg_turn (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  logic [1:0]         axis,
  input  logic signed [15:0] c,
  input  logic signed [15:0] s,
  input  logic signed [47:0] p_in [3],
  input  logic signed [31:0] n_in [3],
  input  logic [66:0]        side_in,
  output logic               vld_out,
  output logic signed [47:0] p_out [3],
  output logic signed [31:0] n_out [3],
  output logic [66:0]        side_out
);
  // axis 0: z turn acts on (x,y); 1: y turn on (z,x); 2: x turn on (y,z)
  logic [1:0] ia, ib;
  logic signed [47:0] p_nxt [3];
  logic signed [31:0] n_nxt [3];
  logic signed [63:0] pa, pb, na, nb;
  always_comb begin
    case (axis)
      2'd0:    begin ia = 2'd0; ib = 2'd1; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd1; ib = 2'd2; end
    endcase
    pa = 64'(c) * 64'(p_in[ia]) - 64'(s) * 64'(p_in[ib]);
    pb = 64'(s) * 64'(p_in[ia]) + 64'(c) * 64'(p_in[ib]);
    na = 64'(c) * 64'(n_in[ia]) - 64'(s) * 64'(n_in[ib]);
    nb = 64'(s) * 64'(n_in[ia]) + 64'(c) * 64'(n_in[ib]);
    p_nxt = p_in;
    n_nxt = n_in;
    p_nxt[ia] = 48'(tvg_pkg::rnd14(pa));
    p_nxt[ib] = 48'(tvg_pkg::rnd14(pb));
    n_nxt[ia] = 32'(tvg_pkg::rnd14(na));
    n_nxt[ib] = 32'(tvg_pkg::rnd14(nb));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_out <= 1'b0;
    else if (en) vld_out <= vld_in;
    if (en) begin
      p_out    <= p_nxt;
      n_out    <= n_nxt;
      side_out <= side_in;
    end
  end
endmodule

[hw/rtl/tvg_xform.sv]
// Vertex pipeline: torus point, three rotation stages, offset and saturation.

// Registered Q1.14 sine of a config angle, three stages deep.
module tvg_trig (
  input  logic               clk,
  input  logic [15:0]        ang,
  output logic signed [15:0] val
);
  logic [14:0] x_nxt, sq_nxt, t_nxt;
  logic [29:0] sq, lin, prod, fin;
  logic [14:0] x1_r, sq_r, x2_r, t_r;
  logic        neg1_r, neg2_r;
  logic signed [15:0] mag;
  always_comb begin
    // fold onto the rising quarter wave
    x_nxt  = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    sq     = 30'(x_nxt) * 30'(x_nxt);
    sq_nxt = sq[28:14];
    lin    = 30'(sq_r) * 30'd1160;
    prod   = 30'(15'd10512 - lin[28:14]) * 30'(sq_r);
    t_nxt  = 15'd25736 - prod[28:14];
    fin    = 30'(t_r) * 30'(x2_r);
    mag    = $signed(fin[29:14]);
  end
  always_ff @(posedge clk) begin
    x1_r   <= x_nxt;
    sq_r   <= sq_nxt;
    neg1_r <= ang[15];
    x2_r   <= x1_r;
    t_r    <= t_nxt;
    neg2_r <= neg1_r;
    val    <= neg2_r ? -mag : mag;
  end
endmodule

module tvg_xform (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  tvg_pkg::job_t   job,
  input  tvg_pkg::cfg_t   cfg,
  output logic            vld_out,
  output tvg_pkg::vert_t  vert
);
  // rotation trig from config, settled before any item reaches the turns
  logic signed [15:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
  tvg_trig u_sin_x (.clk, .ang(cfg.ax), .val(sin_x));
  tvg_trig u_cos_x (.clk, .ang(16'(cfg.ax + 16'd16384)), .val(cos_x));
  tvg_trig u_sin_y (.clk, .ang(cfg.ay), .val(sin_y));
  tvg_trig u_cos_y (.clk, .ang(16'(cfg.ay + 16'd16384)), .val(cos_y));
  tvg_trig u_sin_z (.clk, .ang(cfg.az), .val(sin_z));
  tvg_trig u_cos_z (.clk, .ang(16'(cfg.az + 16'd16384)), .val(cos_z));

  // stage A: dist, tube*sin, texture
  logic vld_a_r;
  tvg_pkg::job_t job_a_r;
  logic signed [47:0] dist_a_r, pz_a_r;
  logic signed [15:0] tu_a_r, tv_a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_a_r <= 1'b0;
    else if (en) vld_a_r <= vld_in;
    if (en) begin
      job_a_r  <= job;
      dist_a_r <= 48'(64'(cfg.ring) + tvg_pkg::rnd14(64'(cfg.tube) * 64'(job.cp)));
      pz_a_r   <= 48'(tvg_pkg::rnd14(64'(cfg.tube) * 64'(job.sp)));
      tu_a_r   <= 16'(tvg_pkg::rnd14(64'(job.ct) * 64'(job.cp)));
      tv_a_r   <= 16'(tvg_pkg::rnd14(-64'(job.st) * 64'(job.cp)));
    end
  end

  // stage B: position in ring plane, tilt
  logic vld_b_r;
  logic signed [47:0] p_b_r [3];
  logic signed [31:0] n_b_r [3];
  logic [66:0] side_b_r;
  logic signed [47:0] px_b, py_b;
  always_comb begin
    px_b = 48'(tvg_pkg::rnd14(64'(job_a_r.ct) * 64'(dist_a_r)));
    py_b = 48'(tvg_pkg::rnd14(-64'(job_a_r.st) * 64'(dist_a_r)));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_b_r <= 1'b0;
    else if (en) vld_b_r <= vld_a_r;
    if (en) begin
      p_b_r[0] <= px_b;
      p_b_r[1] <= job_a_r.tilt ? -pz_a_r : py_b;
      p_b_r[2] <= job_a_r.tilt ? py_b : pz_a_r;
      n_b_r[0] <= 32'(tu_a_r);
      n_b_r[1] <= 32'(tv_a_r);
      n_b_r[2] <= 32'(job_a_r.sp);
      side_b_r <= {tu_a_r, tv_a_r, job_a_r.last, 34'd0};
    end
  end

  logic vz, vy, vx;
  logic signed [47:0] pz [3], py [3], px [3];
  logic signed [31:0] nz [3], ny [3], nx [3];
  logic [66:0] sz, sy, sx;
  tvg_turn u_tz (.clk, .rst_n, .en, .vld_in(vld_b_r), .axis(2'd0),
    .c(cos_z), .s(sin_z),
    .p_in(p_b_r), .n_in(n_b_r), .side_in(side_b_r),
    .vld_out(vz), .p_out(pz), .n_out(nz), .side_out(sz));
  tvg_turn u_ty (.clk, .rst_n, .en, .vld_in(vz), .axis(2'd1),
    .c(cos_y), .s(sin_y),
    .p_in(pz), .n_in(nz), .side_in(sz),
    .vld_out(vy), .p_out(py), .n_out(ny), .side_out(sy));
  tvg_turn u_tx (.clk, .rst_n, .en, .vld_in(vy), .axis(2'd2),
    .c(cos_x), .s(sin_x),
    .p_in(py), .n_in(ny), .side_in(sy),
    .vld_out(vx), .p_out(px), .n_out(nx), .side_out(sx));

  // final stage: offset, saturate
  always_ff @(posedge clk) begin
    if (!rst_n) vld_out <= 1'b0;
    else if (en) vld_out <= vx;
    if (en) begin
      vert.vx   <= tvg_pkg::sat32(64'(px[0]) + 64'(cfg.ox));
      vert.vy   <= tvg_pkg::sat32(64'(px[1]) + 64'(cfg.oy));
      vert.vz   <= tvg_pkg::sat32(64'(px[2]) + 64'(cfg.oz));
      vert.nx   <= tvg_pkg::sat16(64'(nx[0]));
      vert.ny   <= tvg_pkg::sat16(64'(nx[1]));
      vert.nz   <= tvg_pkg::sat16(64'(nx[2]));
      vert.tu   <= sx[66:51];
      vert.tv   <= sx[50:35];
      vert.last <= sx[34];
    end
  end
endmodule

[hw/rtl/torus_vertex_generator.sv]
// Top level of the torus vertex generator: config, pair sequencer, pipeline.
//  channel | dir | handshake        | payload
//  in_     | in  | in_valid/in_stall | ring_step, side_step, inner_tilt
//  out_    | out | out_valid/out_stall | vertex fields, pair_last
//  cfg_    | in  | cfg_we            | cfg_index, cfg_data
// Each input transaction gives two vertex transactions, one per cycle while out_ is
// not stalled; no new input is taken until the second is issued, and the sequencer
// issuing the pair sets that. Each item passes stage A, stage B, the z, y and x turns
// and the final offset stage into the output register. Reset clears valid bits and
// config registers. A stall on out_ while out_valid is high freezes the whole pipeline;
// nothing is lost or repeated. After reset and after each config write in_stall stays
// high while the rotation sine/cosine registers settle.
`include "torus_vertex_generator_macros.svh"
module torus_vertex_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_ring_step,
  input  logic [3:0]         in_side_step,
  input  logic               in_inner_tilt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vert_x,
  output logic signed [31:0] out_vert_y,
  output logic signed [31:0] out_vert_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic signed [15:0] out_tex_u,
  output logic signed [15:0] out_tex_v,
  output logic               out_pair_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  tvg_pkg::cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_we) begin
      case (cfg_index)
        tvg_pkg::REG_TUBE: cfg_r.tube <= cfg_data;
        tvg_pkg::REG_RING: cfg_r.ring <= cfg_data;
        tvg_pkg::REG_AX:   cfg_r.ax   <= cfg_data[15:0];
        tvg_pkg::REG_AY:   cfg_r.ay   <= cfg_data[15:0];
        tvg_pkg::REG_AZ:   cfg_r.az   <= cfg_data[15:0];
        tvg_pkg::REG_OX:   cfg_r.ox   <= cfg_data;
        tvg_pkg::REG_OY:   cfg_r.oy   <= cfg_data;
        tvg_pkg::REG_OZ:   cfg_r.oz   <= cfg_data;
        default: ;
      endcase
    end
  end

  // settle_r: cycles left until the config trig registers are valid
  logic [1:0] settle_r;
  logic busy;
  assign busy = settle_r != 2'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= tvg_pkg::TRIG_LAT;
    else if (cfg_we) settle_r <= tvg_pkg::TRIG_LAT;
    else if (busy) settle_r <= settle_r - 2'd1;
  end

  logic en;
  assign en = !out_stall || !out_valid;

  // second_r: the held item still owes its current-ring vertex
  logic second_r;
  logic [2:0] k_r;
  logic [3:0] j_r;
  logic tilt_r;
  assign in_stall = second_r || !en || busy;

  logic [2:0] k_sel;
  logic [3:0] j_sel;
  logic tilt_sel, issue;
  tvg_pkg::job_t job;
  always_comb begin
    k_sel    = second_r ? k_r : in_ring_step;
    j_sel    = second_r ? j_r : in_side_step;
    tilt_sel = second_r ? tilt_r : in_inner_tilt;
    issue    = second_r || (in_valid && !busy);
    job.ct   = tvg_pkg::ring_cos(second_r ? {1'b0, k_sel} : 4'({1'b0, k_sel} + 4'd1));
    job.st   = tvg_pkg::ring_sin(second_r ? {1'b0, k_sel} : 4'({1'b0, k_sel} + 4'd1));
    job.cp   = tvg_pkg::side_cos(5'({1'b0, j_sel} + 5'd1));
    job.sp   = tvg_pkg::side_sin(5'({1'b0, j_sel} + 5'd1));
    job.tilt = tilt_sel;
    job.last = second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) second_r <= 1'b0;
    else if (en) second_r <= !second_r && in_valid && !busy;
    if (en && !second_r) begin
      k_r    <= in_ring_step;
      j_r    <= in_side_step;
      tilt_r <= in_inner_tilt;
    end
  end

  tvg_pkg::vert_t vert;
  tvg_xform u_xform (.clk, .rst_n, .en, .vld_in(issue), .job, .cfg(cfg_r),
    .vld_out(out_valid), .vert);

  assign out_vert_x    = vert.vx;
  assign out_vert_y    = vert.vy;
  assign out_vert_z    = vert.vz;
  assign out_norm_x    = vert.nx;
  assign out_norm_y    = vert.ny;
  assign out_norm_z    = vert.nz;
  assign out_tex_u     = vert.tu;
  assign out_tex_v     = vert.tv;
  assign out_pair_last = vert.last;

  `TVG_ASSERT_NEXT(a_pair_follows, in_valid && !in_stall, second_r)
  `TVG_ASSERT_IMPL(a_no_take_second, second_r, in_stall)
  `TVG_ASSERT_IMPL(a_no_take_settling, busy, in_stall)
  `TVG_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid && $stable(out_vert_x))
endmodule

[tb/tb_torus_vertex_generator.sv]
// Testbench for the torus vertex generator: directed and random cells, checked against a predictor.
`timescale 1ns / 1ps
module tb_torus_vertex_generator;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [15:0] nx, ny, nz, tu, tv;
    logic last;
  } vertex_s;

  // Scoreboard: holds the transformation settings and the queue of expected vertices.
  class vertex_scoreboard;
    logic signed [31:0] tube, ring, ox, oy, oz;
    logic [15:0] ax, ay, az;
    vertex_s pending[$];
    int errors;

    function new();
      tube = 0; ring = 0; ox = 0; oy = 0; oz = 0; ax = 0; ay = 0; az = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        tvg_pkg::REG_TUBE: tube = val;
        tvg_pkg::REG_RING: ring = val;
        tvg_pkg::REG_AX:   ax = val[15:0];
        tvg_pkg::REG_AY:   ay = val[15:0];
        tvg_pkg::REG_AZ:   az = val[15:0];
        tvg_pkg::REG_OX:   ox = val;
        tvg_pkg::REG_OY:   oy = val;
        default:           oz = val;
      endcase
    endfunction

    function longint quarter_wave(longint f);
      longint x2, t;
      x2 = (f * f) >>> 14;
      t = (1160 * x2) >>> 14;
      t = 10512 - t;
      t = (t * x2) >>> 14;
      t = 25736 - t;
      return (t * f) >>> 14;
    endfunction

    function longint sine(logic [15:0] a);
      longint s;
      s = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
      return a[15] ? -s : s;
    endfunction

    function longint cosine(logic [15:0] a);
      logic [15:0] b;
      b = a + 16'd16384;
      return sine(b);
    endfunction

    function logic [15:0] angle_of(int stp, int slices);
      longint v;
      v = (longint'(stp) * 65536 + slices / 2) / slices;
      return v[15:0];
    endfunction

    function longint round14(longint p);
      return (p + 8192) >>> 14;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void turn(ref longint a, ref longint b, input logic [15:0] ang);
      longint c, s, na;
      c = cosine(ang);
      s = sine(ang);
      na = round14(c * a - s * b);
      b = round14(s * a + c * b);
      a = na;
    endfunction

    function void rotate(ref longint x, ref longint y, ref longint z);
      turn(x, y, az);
      turn(z, x, ay);
      turn(y, z, ax);
    endfunction

    function vertex_s vertex_at(logic [15:0] th, longint cp, longint sp, bit tilt, bit last);
      vertex_s v;
      longint ct, st, radial, px, py, pz, nx, ny, nz, tu, tv, t;
      ct = cosine(th);
      st = sine(th);
      radial = longint'(ring) + round14(longint'(tube) * cp);
      px = round14(ct * radial);
      py = round14(-st * radial);
      pz = round14(longint'(tube) * sp);
      tu = round14(ct * cp);
      tv = round14(-st * cp);
      nx = tu; ny = tv; nz = sp;
      if (tilt) begin
        t = py; py = -pz; pz = t;
      end
      rotate(px, py, pz);
      rotate(nx, ny, nz);
      v.vx = 32'(clip(px + ox, 32));
      v.vy = 32'(clip(py + oy, 32));
      v.vz = 32'(clip(pz + oz, 32));
      v.nx = 16'(clip(nx, 16));
      v.ny = 16'(clip(ny, 16));
      v.nz = 16'(clip(nz, 16));
      v.tu = 16'(tu);
      v.tv = 16'(tv);
      v.last = last;
      return v;
    endfunction

    function void queue_vertex(vertex_s v);
      pending = {pending, v};
    endfunction

    function void note_cell(logic [2:0] k, logic [3:0] j, bit tilt);
      logic [15:0] phi;
      longint cp, sp;
      phi = angle_of(j + 1, tvg_pkg::SIDE_SLICES);
      cp = cosine(phi);
      sp = sine(phi);
      queue_vertex(vertex_at(angle_of(k + 1, tvg_pkg::RING_SLICES), cp, sp, tilt, 1'b0));
      queue_vertex(vertex_at(angle_of(k, tvg_pkg::RING_SLICES), cp, sp, tilt, 1'b1));
    endfunction

    function void check_vertex(vertex_s got);
      vertex_s e;
      if (pending.size() == 0) begin
        $error("unexpected vertex transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.vx !== e.vx) begin $error("vert_x exp %0d got %0d", e.vx, got.vx); errors++; end
      if (got.vy !== e.vy) begin $error("vert_y exp %0d got %0d", e.vy, got.vy); errors++; end
      if (got.vz !== e.vz) begin $error("vert_z exp %0d got %0d", e.vz, got.vz); errors++; end
      if (got.nx !== e.nx) begin $error("norm_x exp %0d got %0d", e.nx, got.nx); errors++; end
      if (got.ny !== e.ny) begin $error("norm_y exp %0d got %0d", e.ny, got.ny); errors++; end
      if (got.nz !== e.nz) begin $error("norm_z exp %0d got %0d", e.nz, got.nz); errors++; end
      if (got.tu !== e.tu) begin $error("tex_u exp %0d got %0d", e.tu, got.tu); errors++; end
      if (got.tv !== e.tv) begin $error("tex_v exp %0d got %0d", e.tv, got.tv); errors++; end
      if (got.last !== e.last) begin
        $error("pair_last exp %0d got %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_ring_step = '0;
  logic [3:0] in_side_step = '0;
  logic in_inner_tilt = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_vert_x, out_vert_y, out_vert_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z, out_tex_u, out_tex_v;
  logic out_pair_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // idle percentages for each side, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  vertex_scoreboard sb = new();

  always #1 clk = ~clk;

  torus_vertex_generator dut (.*);

  // Receiver: random stall, result transactions checked at the edge they are taken.
  always @(posedge clk) begin
    vertex_s got;
    if (rst_n && out_valid && !out_stall) begin
      got.vx = out_vert_x; got.vy = out_vert_y; got.vz = out_vert_z;
      got.nx = out_norm_x; got.ny = out_norm_y; got.nz = out_norm_z;
      got.tu = out_tex_u; got.tv = out_tex_v; got.last = out_pair_last;
      sb.check_vertex(got);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[torus_vertex_generator] ERROR");
        $finish;
      end
    end
  end

  // One input transaction; valid stays high across back-to-back cells.
  task automatic send_cell(logic [2:0] k, logic [3:0] j, bit tilt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ring_step <= k;
    in_side_step <= j;
    in_inner_tilt <= tilt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_cell(k, j, tilt);
  endtask

  // Waits until every expected vertex is out, plus the pipe latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(logic [31:0] tube, logic [31:0] ring, logic [15:0] ax,
                               logic [15:0] ay, logic [15:0] az, logic [31:0] ox,
                               logic [31:0] oy, logic [31:0] oz);
    write_reg(tvg_pkg::REG_TUBE, tube);
    write_reg(tvg_pkg::REG_RING, ring);
    write_reg(tvg_pkg::REG_AX, {16'd0, ax});
    write_reg(tvg_pkg::REG_AY, {16'd0, ay});
    write_reg(tvg_pkg::REG_AZ, {16'd0, az});
    write_reg(tvg_pkg::REG_OX, ox);
    write_reg(tvg_pkg::REG_OY, oy);
    write_reg(tvg_pkg::REG_OZ, oz);
  endtask

  task automatic random_cells(int n);
    repeat (n) send_cell(3'($urandom_range(7)), 4'($urandom_range(15)),
                         1'($urandom_range(1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all zero, positions collapse to the origin.
    send_cell(3'd0, 4'd0, 1'b0);
    send_cell(3'd7, 4'd15, 1'b1);
    drain();

    // Plain torus, no rotation: steps past the slice count wrap the angle.
    load_settings(32'sh0001_0000, 32'sh0003_0000, 16'd0, 16'd0, 16'd0, 0, 0, 0);
    for (int j = 0; j < 16; j += 3) send_cell(j[2:0], j[3:0], j[0]);
    send_cell(3'd7, 4'd8, 1'b1);
    send_cell(3'd3, 4'd15, 1'b0);
    drain();

    // Extreme radii and offsets force position saturation both ways.
    load_settings(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 16'h8000, 16'h4000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    for (int i = 0; i < 4; i++) send_cell(i[2:0], 4'(i * 4), i[0]);
    drain();
    load_settings(32'sh8000_0000, 32'sh8000_0000, 16'h2000, 16'hE000, 16'hFFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    for (int i = 0; i < 4; i++) send_cell(3'(7 - i), 4'(15 - i * 3), i[1]);
    drain();

    // Random phases: idling pattern and settings change per phase.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph % 3 == 0) begin
        // moderate radii keep most vertices in range
        load_settings($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
                      $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000,
                      16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)), $urandom(), $urandom(), $urandom());
      end else begin
        load_settings($urandom(), $urandom(), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                      $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000,
                      $urandom(), $signed($urandom_range(32'h0000_FFFF)));
      end
      random_cells(125);
      drain();
    end

    if (sb.errors == 0) begin
      $display("[torus_vertex_generator] OK");
    end else begin
      $display("[torus_vertex_generator] ERROR");
    end
    $finish;
  end
endmodule
